// ----- hw/rtl/rcp_pkg.sv -----
// ---------------------------------------------------------------------------
// RESP command parser package
// Item types, parse phase codes, character constants and configuration
// defaults shared by the parser modules.
// ---------------------------------------------------------------------------
package rcp_pkg;

    // Default bulk string limit; the top level hands it down as a parameter.
    localparam int unsigned MAX_STRING_BYTES_DEFAULT = 255;

    // Configuration register defaults.
    localparam logic [15:0] ADDRESS_MASK_RESET   = 16'hFFFF;
    localparam logic [15:0] ADDRESS_OFFSET_RESET = 16'h0000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_ADDRESS_MASK   = 1'b0,
        CFG_ADDRESS_OFFSET = 1'b1
    } cfg_index_t;

    // Protocol characters.
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Command names that are recognized.
    localparam logic [7:0] GET_TEXT [3] = '{8'h47, 8'h45, 8'h54};
    localparam logic [7:0] SET_TEXT [3] = '{8'h53, 8'h45, 8'h54};

    // Parse phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_ARR_HDR  = 8'b0000_0010,
        PH_BULK_HDR = 8'b0000_0100,
        PH_BODY     = 8'b0000_1000,
        PH_TRAIL    = 8'b0001_0000,
        PH_WANT_LF  = 8'b0010_0000,
        PH_LINE     = 8'b0100_0000,
        PH_ERRLINE  = 8'b1000_0000
    } phase_t;

    // Per-message flags.
    typedef struct packed {
        logic too_long;
        logic is_error;
        logic has_response;
        logic is_set;
        logic is_get;
    } msg_flags_t;

    // One input item: a payload byte and its end-of-message mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One result item: the message summary.
    typedef struct packed {
        logic        is_get;
        logic        is_set;
        logic        has_response;
        logic        is_error;
        logic [31:0] key_word;
        logic [7:0]  key_length;
        logic [15:0] key_address;
        logic [31:0] value_word;
        logic [7:0]  value_length;
        logic [31:0] response_word;
        logic        too_long;
    } out_item_t;

endpackage

// ----- hw/rtl/rcp_stream_if.sv -----
// ---------------------------------------------------------------------------
// RESP parser stream channel
// Valid/ready channel carrying one payload item per handshake.
// ---------------------------------------------------------------------------
interface rcp_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rcp_input_stage.sv -----
// ---------------------------------------------------------------------------
// RESP parser input stage
// Registers one incoming byte item; a new item is taken in the same cycle
// the held one moves on to the parser.
// ---------------------------------------------------------------------------
module rcp_input_stage (
    input  logic             clk,
    input  logic             rst_n,
    rcp_stream_if.sink       byte_stream,
    input  logic             advance,
    output logic             item_valid,
    output rcp_pkg::in_item_t item
);
    import rcp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Free when empty or when the held item is consumed this cycle.
    assign byte_stream.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_stream.ready)
        begin
            valid_next = byte_stream.valid;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            item_reg <= byte_stream.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    // A consumed item must have been present.
    a_advance_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> valid_reg)
        else $error("input stage advanced without an item");

endmodule

// ----- hw/rtl/rcp_parser.sv -----
// ---------------------------------------------------------------------------
// RESP parser core
// Holds the message parse state, updates it for one byte per cycle when
// advanced and forms the message summary when a message's last byte passes.
// ---------------------------------------------------------------------------
module rcp_parser #(
    parameter int unsigned MAX_STRING_BYTES = rcp_pkg::MAX_STRING_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  rcp_pkg::in_item_t item,
    input  logic [15:0]       address_mask,
    input  logic [15:0]       address_offset,
    output rcp_pkg::out_item_t result
);
    import rcp_pkg::*;

    // String position saturates one past the limit.
    localparam int unsigned POS_W  = $clog2(MAX_STRING_BYTES + 2);
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_STRING_BYTES + 1);

    phase_t           phase_reg,     phase_next;
    logic [15:0]      acc_reg,       acc_next;
    logic             neg_reg,       neg_next;
    logic [15:0]      elems_reg,     elems_next;
    logic [15:0]      remain_reg,    remain_next;
    logic [15:0]      mid_tgt_reg,   mid_tgt_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic             three_reg,     three_next;
    logic [7:0]       cur_len_reg,   cur_len_next;
    logic [31:0]      word_reg,      word_next;
    logic [7:0]       mid_reg,       mid_next;
    logic [1:0]       match_reg,     match_next;
    msg_flags_t       flags_reg,     flags_next;
    logic [31:0]      key_word_reg,  key_word_next;
    logic [7:0]       key_len_reg,   key_len_next;
    logic [7:0]       key_mid_reg,   key_mid_next;
    logic [31:0]      val_word_reg,  val_word_next;
    logic [7:0]       val_len_reg,   val_len_next;
    logic [31:0]      resp_word_reg, resp_word_next;

    // Byte capture into the current string.
    logic [7:0]       b;
    logic [31:0]      cap_word;
    logic [1:0]       cap_match;
    logic [POS_W-1:0] pos_inc;

    always_comb
    begin
        b        = item.data_byte;
        cap_word = word_reg;
        cap_match = match_reg;
        if (pos_reg < POS_W'(4))
        begin
            unique case (pos_reg[1:0])
                2'd0:    cap_word[31:24] = b;
                2'd1:    cap_word[23:16] = b;
                2'd2:    cap_word[15:8]  = b;
                default: cap_word[7:0]   = b;
            endcase
        end
        if (pos_reg < POS_W'(3))
        begin
            if (b != GET_TEXT[pos_reg[1:0]])
            begin
                cap_match[0] = 1'b0;
            end
            if (b != SET_TEXT[pos_reg[1:0]])
            begin
                cap_match[1] = 1'b0;
            end
        end
        pos_inc = (pos_reg == POS_SAT) ? pos_reg : pos_reg + POS_W'(1);
    end

    // Next-state logic for one accepted byte.
    logic        do_dispatch;
    logic        do_finish;
    logic [31:0] fin_word;
    logic [1:0]  fin_match;
    logic        fin_three;
    logic [7:0]  fin_len;
    logic [7:0]  fin_mid;
    logic [19:0] acc_prod;
    logic [15:0] key_addr_raw;

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        elems_next     = elems_reg;
        remain_next    = remain_reg;
        mid_tgt_next   = mid_tgt_reg;
        pos_next       = pos_reg;
        three_next     = three_reg;
        cur_len_next   = cur_len_reg;
        word_next      = word_reg;
        mid_next       = mid_reg;
        match_next     = match_reg;
        flags_next     = flags_reg;
        key_word_next  = key_word_reg;
        key_len_next   = key_len_reg;
        key_mid_next   = key_mid_reg;
        val_word_next  = val_word_reg;
        val_len_next   = val_len_reg;
        resp_word_next = resp_word_reg;
        do_dispatch    = 1'b0;
        do_finish      = 1'b0;
        fin_word       = cap_word;
        fin_match      = cap_match;
        fin_three      = three_reg;
        fin_len        = cur_len_reg;
        fin_mid        = mid_reg;
        acc_prod       = 20'(acc_reg) * 20'd10 + 20'(b - CH_ZERO);

        unique case (phase_reg)
            PH_ARR_HDR, PH_BULK_HDR:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (acc_prod > 20'hFFFF)
                    begin
                        acc_next = 16'hFFFF;
                        flags_next.too_long = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_prod[15:0];
                    end
                end
                else if (b == CH_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if (b == CH_LF)
                begin
                    if (phase_reg == PH_ARR_HDR)
                    begin
                        elems_next = neg_reg ? 16'd0 : acc_reg;
                        phase_next = PH_IDLE;
                    end
                    else if (neg_reg)
                    begin
                        // Null bulk string only uses up an element.
                        elems_next = elems_reg - 16'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        cur_len_next = (acc_reg > 16'd255) ? 8'd255 : acc_reg[7:0];
                        if (32'(acc_reg) > MAX_STRING_BYTES)
                        begin
                            flags_next.too_long = 1'b1;
                        end
                        remain_next  = acc_reg;
                        mid_tgt_next = acc_reg - (acc_reg >> 1);
                        three_next   = (acc_reg == 16'd3);
                        pos_next     = '0;
                        word_next    = '0;
                        mid_next     = '0;
                        match_next   = 2'b11;
                        if (acc_reg == 16'd0)
                        begin
                            // Empty string is classified at once.
                            do_finish = 1'b1;
                            fin_word  = '0;
                            fin_match = 2'b11;
                            fin_three = 1'b0;
                            fin_len   = 8'd0;
                            fin_mid   = 8'd0;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY:
            begin
                word_next  = cap_word;
                match_next = cap_match;
                pos_next   = pos_inc;
                if (remain_reg == mid_tgt_reg)
                begin
                    mid_next = b;
                    fin_mid  = b;
                end
                remain_next = remain_reg - 16'd1;
                if (remain_reg == 16'd1)
                begin
                    do_finish = 1'b1;
                end
            end
            PH_TRAIL:
            begin
                if (b == CH_CR)
                begin
                    phase_next = PH_WANT_LF;
                end
                else
                begin
                    do_dispatch = 1'b1;
                end
            end
            PH_WANT_LF:
            begin
                if (b == CH_LF)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    do_dispatch = 1'b1;
                end
            end
            PH_LINE:
            begin
                if (b == CH_CR)
                begin
                    resp_word_next          = word_reg;
                    flags_next.is_set       = 1'b1;
                    flags_next.has_response = 1'b1;
                    phase_next              = PH_WANT_LF;
                end
                else
                begin
                    word_next  = cap_word;
                    match_next = cap_match;
                    pos_next   = pos_inc;
                    if (32'(pos_inc) > MAX_STRING_BYTES)
                    begin
                        flags_next.too_long = 1'b1;
                    end
                end
            end
            PH_ERRLINE:
            begin
                if (b == CH_CR)
                begin
                    phase_next = PH_WANT_LF;
                end
            end
            default:
            begin
                do_dispatch = 1'b1;
            end
        endcase

        // Start of a new element.
        if (do_dispatch)
        begin
            acc_next = '0;
            neg_next = 1'b0;
            priority if (b == CH_STAR)
            begin
                phase_next = PH_ARR_HDR;
            end
            else if (b == CH_DOLLAR)
            begin
                phase_next = PH_BULK_HDR;
            end
            else if (b == CH_PLUS)
            begin
                pos_next   = '0;
                word_next  = '0;
                mid_next   = '0;
                match_next = 2'b11;
                phase_next = PH_LINE;
            end
            else if (b == CH_MINUS)
            begin
                flags_next.is_error = 1'b1;
                phase_next          = PH_ERRLINE;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end

        // Classify a completed bulk string.
        if (do_finish)
        begin
            priority if (fin_three && fin_match[0])
            begin
                flags_next.is_get = 1'b1;
            end
            else if (fin_three && fin_match[1])
            begin
                flags_next.is_set = 1'b1;
            end
            else if ((flags_reg.is_get && elems_reg == 16'd1) ||
                     (flags_reg.is_set && elems_reg == 16'd2))
            begin
                key_word_next = fin_word;
                key_len_next  = fin_len;
                key_mid_next  = fin_mid;
            end
            else if (flags_reg.is_set)
            begin
                val_word_next = fin_word;
                val_len_next  = fin_len;
            end
            else
            begin
                resp_word_next          = fin_word;
                flags_next.is_get       = 1'b1;
                flags_next.has_response = 1'b1;
            end
            elems_next = elems_reg - 16'd1;
            phase_next = PH_TRAIL;
        end

        // Summary from the state after this byte.
        key_addr_raw         = {key_word_next[31:24], key_mid_next};
        result.is_get        = flags_next.is_get;
        result.is_set        = flags_next.is_set;
        result.has_response  = flags_next.has_response;
        result.is_error      = flags_next.is_error;
        result.key_word      = key_word_next;
        result.key_length    = key_len_next;
        result.key_address   = (key_addr_raw & address_mask) + address_offset;
        result.value_word    = val_word_next;
        result.value_length  = val_len_next;
        result.response_word = resp_word_next;
        result.too_long      = flags_next.too_long;

        // The parser starts over after every message.
        if (item.last_byte)
        begin
            phase_next     = PH_IDLE;
            acc_next       = '0;
            neg_next       = 1'b0;
            elems_next     = '0;
            remain_next    = '0;
            mid_tgt_next   = '0;
            pos_next       = '0;
            three_next     = 1'b0;
            cur_len_next   = '0;
            word_next      = '0;
            mid_next       = '0;
            match_next     = 2'b11;
            flags_next     = '0;
            key_word_next  = '0;
            key_len_next   = '0;
            key_mid_next   = '0;
            val_word_next  = '0;
            val_len_next   = '0;
            resp_word_next = '0;
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            elems_reg     <= '0;
            remain_reg    <= '0;
            mid_tgt_reg   <= '0;
            pos_reg       <= '0;
            three_reg     <= 1'b0;
            cur_len_reg   <= '0;
            word_reg      <= '0;
            mid_reg       <= '0;
            match_reg     <= 2'b11;
            flags_reg     <= '0;
            key_word_reg  <= '0;
            key_len_reg   <= '0;
            key_mid_reg   <= '0;
            val_word_reg  <= '0;
            val_len_reg   <= '0;
            resp_word_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            elems_reg     <= elems_next;
            remain_reg    <= remain_next;
            mid_tgt_reg   <= mid_tgt_next;
            pos_reg       <= pos_next;
            three_reg     <= three_next;
            cur_len_reg   <= cur_len_next;
            word_reg      <= word_next;
            mid_reg       <= mid_next;
            match_reg     <= match_next;
            flags_reg     <= flags_next;
            key_word_reg  <= key_word_next;
            key_len_reg   <= key_len_next;
            key_mid_reg   <= key_mid_next;
            val_word_reg  <= val_word_next;
            val_len_reg   <= val_len_next;
            resp_word_reg <= resp_word_next;
        end
    end

    // A message end leaves the parser idle with no flags.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last_byte |=> phase_reg == PH_IDLE && flags_reg == '0)
        else $error("parser state not cleared after message end");

    // Phase register stays one-hot.
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    // A string body is only entered with bytes still to come.
    a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> remain_reg != 16'd0)
        else $error("string body with no bytes remaining");

endmodule

// ----- hw/rtl/rcp_result_reg.sv -----
// ---------------------------------------------------------------------------
// RESP parser result register
// Holds one message summary until the downstream side takes it.
// ---------------------------------------------------------------------------
module rcp_result_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  rcp_pkg::out_item_t result,
    output logic               can_load,
    rcp_stream_if.source       summary
);
    import rcp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // Room when empty or when the held item leaves this cycle.
    assign can_load = !valid_reg || summary.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (summary.ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Summary payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign summary.valid = valid_reg;
    assign summary.data  = data_reg;

    // A held summary is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !valid_reg || summary.ready)
        else $error("result register overwritten while held");

endmodule

// ----- hw/rtl/resp_command_parser.sv -----
// ---------------------------------------------------------------------------
// RESP command parser
// Byte-stream parser for RESP messages producing one summary per message.
// ---------------------------------------------------------------------------
// One payload byte is taken per cycle. Each byte is registered, then the
// parse state is updated from it; the byte that ends a message also loads
// the summary register as it moves on, so a summary is offered in the cycle
// after its last byte leaves the input register. Intake pauses only when a
// last byte waits while the previous summary has not yet been taken.
// Configuration writes should be made while no message is in flight.
module resp_command_parser #(
    parameter int unsigned MAX_STRING_BYTES = rcp_pkg::MAX_STRING_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    rcp_stream_if.sink          byte_stream,
    rcp_stream_if.source        summary,
    input  logic                cfg_write,
    input  rcp_pkg::cfg_index_t cfg_index,
    input  logic [15:0]         cfg_data
);
    import rcp_pkg::*;

    logic [15:0] address_mask_reg;
    logic [15:0] address_offset_reg;
    logic        item_valid;
    in_item_t    item;
    logic        advance;
    logic        can_load;
    out_item_t   result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_mask_reg   <= ADDRESS_MASK_RESET;
            address_offset_reg <= ADDRESS_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ADDRESS_MASK:   address_mask_reg   <= cfg_data;
                CFG_ADDRESS_OFFSET: address_offset_reg <= cfg_data;
                default:            address_mask_reg   <= address_mask_reg;
            endcase
        end
    end

    // A byte moves on unless it ends a message and the summary slot is full and not being taken.
    assign advance = item_valid && (!item.last_byte || can_load);

    rcp_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    rcp_parser #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .item           (item),
        .address_mask   (address_mask_reg),
        .address_offset (address_offset_reg),
        .result         (result)
    );

    rcp_result_reg u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && item.last_byte),
        .result   (result),
        .can_load (can_load),
        .summary  (summary)
    );

    // A byte that ends a message must produce a summary next cycle.
    a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last_byte |=> summary.valid)
        else $error("message end did not produce a summary");

endmodule
